FILE: src/tsb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tagged slot buffer.
// Used by tsb_slot_tags, tagged_slot_buffer_core, tsb_checker and testbench; no dependencies.
package tsb_pkg;

   // Storage geometry
   localparam int SLOTS     = 16;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int KEY_W     = 16;
   localparam int PAYLOAD_W = 32;

   // Field widths fixed by the interface
   localparam int IDX_W = 4;
   localparam int CNT_W = 5;

   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_WRITTEN   = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_FETCH = 2'd1,
      S_HOLD  = 2'd2
   } state_type;

   typedef struct packed {
      action_type           action;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [IDX_W-1:0]     slot_index;
      logic [KEY_W-1:0]     out_key;
      logic [PAYLOAD_W-1:0] out_payload;
   } rsp_type;

   // Search request from the controller to the tag array
   typedef struct packed {
      logic             go;
      action_type       action;
      logic [KEY_W-1:0] key;
   } lookup_type;

   // Search outcome from the tag array
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } find_type;

endpackage

FILE: src/tsb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tsb_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/tsb_slot_tags.sv
`timescale 1ns / 1ps
// Slot valid bits and keys with parallel compare and priority encode.
// Depends on tsb_pkg.
module tsb_slot_tags (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [tsb_pkg::CNT_W-1:0] slot_count,
   input  tsb_pkg::lookup_type       lookup,
   output tsb_pkg::find_type         find
);
   import tsb_pkg::*;

   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] valid_in;
   logic [KEY_W-1:0] key_ff [SLOTS];
   logic [SLOTS-1:0] in_use;
   logic [SLOTS-1:0] cand;
   logic             hit;
   logic [SLOT_W-1:0] slot;

   // Mark slots in use and pick candidates for this action
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         in_use[i] = (i < int'(slot_count));
         if (lookup.action == ACT_WRITE) begin
            cand[i] = in_use[i] && !valid_ff[i];
         end else begin
            cand[i] = in_use[i] && valid_ff[i] && (key_ff[i] == lookup.key);
         end
      end
   end

   // Lowest-numbered candidate wins
   always_comb begin
      hit  = 1'b0;
      slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            hit  = 1'b1;
            slot = SLOT_W'(i);
         end
      end
   end

   assign find.hit  = hit;
   assign find.slot = slot;

   // Set on a stored write, clear on a found read
   always_comb begin
      valid_in = valid_ff;
      if (lookup.go && hit) begin
         valid_in[slot] = (lookup.action == ACT_WRITE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Keys need no reset
   always_ff @(posedge clock) begin
      if (lookup.go && hit && lookup.action == ACT_WRITE) begin
         key_ff[slot] <= lookup.key;
      end
   end

endmodule

FILE: src/tagged_slot_buffer_core.sv
`timescale 1ns / 1ps
// Tagged slot buffer: keyed slot store with first-free write, first-match read.
// Depends on tsb_pkg, tsb_slot_tags and tsb_ram.
//
// Usage:
//   req channel (req_valid / req_stall / req_data): one action per transfer.
//     A write stores key and payload in the lowest free slot below the slot
//     count, a read removes the lowest valid slot whose key matches.
//   rsp channel (rsp_valid / rsp_stall / rsp_data): exactly one result per
//     request, in order.
//   csr channel (csr_valid / csr_ready / csr_data): sets the slot count;
//     always ready, write only while the block is idle.
// Timing: a request is searched in the cycle it is taken, and the payload RAM
//   is read or written at that edge; the registered read data forms the result
//   in S_FETCH. No new request is taken until the block is back in S_IDLE.
// Stall: a result that cannot leave is parked in a hold register; the next
//   request is taken once the hold register has moved into the result
//   register, so a stall on rsp backs up into req_stall.
// Reset: all slots empty, slot count 16, no result pending. No clearing pass.
module tagged_slot_buffer_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tsb_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tsb_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [tsb_pkg::CNT_W-1:0] csr_data
);
   import tsb_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff;
   logic                 accept;
   lookup_type           lookup;
   find_type             find;
   logic [PAYLOAD_W-1:0] rd_data;

   action_type           act_ff;
   logic [KEY_W-1:0]     key_ff;
   logic                 hit_ff;
   logic [SLOT_W-1:0]    slot_ff;

   rsp_type              result;
   rsp_type              hold_ff, hold_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   // Configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   // Take a request only when idle
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign lookup.go     = accept;
   assign lookup.action = req_data.action;
   assign lookup.key    = req_data.key;

   tsb_slot_tags u_tags (
      .clock      (clock),
      .reset      (reset),
      .slot_count (count_ff),
      .lookup     (lookup),
      .find       (find)
   );

   tsb_ram #(
      .DEPTH (SLOTS),
      .WIDTH (PAYLOAD_W)
   ) u_payload (
      .clock   (clock),
      .wr_en   (accept && find.hit && req_data.action == ACT_WRITE),
      .wr_addr (find.slot),
      .wr_data (req_data.payload),
      .rd_en   (accept && req_data.action == ACT_READ),
      .rd_addr (find.slot),
      .rd_data (rd_data)
   );

   // Capture the request and search outcome for the result cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_data.action;
         key_ff  <= req_data.key;
         hit_ff  <= find.hit;
         slot_ff <= find.slot;
      end
   end

   // Build the result from the search outcome and RAM data
   always_comb begin
      result = '0;
      if (act_ff == ACT_WRITE) begin
         result.status = hit_ff ? ST_WRITTEN : ST_FULL;
      end else begin
         result.status = hit_ff ? ST_FOUND : ST_NOT_FOUND;
         if (hit_ff) begin
            result.out_key     = key_ff;
            result.out_payload = rd_data;
         end
      end
      if (hit_ff) begin
         result.slot_index = IDX_W'(slot_ff);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and output register loading
   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (out_free) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               hold_in  = result;
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A taken request is always followed by its result cycle
   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_FETCH)
      else $error("request not followed by fetch cycle");

   // The hold register is only used while the output is occupied
   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD |-> rsp_valid_ff)
      else $error("result parked with output register empty");

   // A hit never lands outside the searched range
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH && hit_ff |-> int'(slot_ff) < int'(count_ff))
      else $error("slot hit beyond slot count");

   // A fetch cycle always ends with a loaded or parked result
   a_fetch_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |=> rsp_valid_ff)
      else $error("fetch cycle produced no result");

endmodule

FILE: tb/tsb_checker.sv
`timescale 1ns / 1ps
// Result checker for tagged_slot_buffer_core: watches the req, rsp and csr channels,
// predicts each result from its own copy of the slot store and compares in order.
// Depends on tsb_pkg.
module tsb_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  tsb_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  tsb_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [tsb_pkg::CNT_W-1:0] csr_data,
   input  logic                      final_check,
   output int                        pending,
   output int                        failures
);
   import tsb_pkg::*;

   // Predicted slot store and slot count
   logic                 slot_live [SLOTS];
   logic [KEY_W-1:0]     slot_tag  [SLOTS];
   logic [PAYLOAD_W-1:0] slot_word [SLOTS];
   logic [CNT_W-1:0]     slot_count;

   rsp_type expected_results[$];
   int      error_count;
   bit      leftovers_done;

   initial begin
      pending  = 0;
      failures = 0;
   end

   // Apply one request to the predicted store and return its result
   function automatic rsp_type serve_request(req_type r);
      rsp_type res;
      int      reach;
      bit      hit;
      res   = '0;
      hit   = 1'b0;
      reach = (int'(slot_count) > SLOTS) ? SLOTS : int'(slot_count);
      if (r.action == ACT_WRITE) begin
         for (int i = 0; i < reach && !hit; i++) begin
            if (!slot_live[i]) begin
               slot_live[i]   = 1'b1;
               slot_tag[i]    = r.key;
               slot_word[i]   = r.payload;
               res.slot_index = IDX_W'(i);
               hit            = 1'b1;
            end
         end
         res.status = hit ? ST_WRITTEN : ST_FULL;
      end else begin
         for (int i = 0; i < reach && !hit; i++) begin
            if (slot_live[i] && slot_tag[i] == r.key) begin
               slot_live[i]    = 1'b0;
               res.slot_index  = IDX_W'(i);
               res.out_key     = slot_tag[i];
               res.out_payload = slot_word[i];
               hit             = 1'b1;
            end
         end
         res.status = hit ? ST_FOUND : ST_NOT_FOUND;
      end
      return res;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_tag[i]  = '0;
            slot_word[i] = '0;
         end
         slot_count = CNT_RESET;
         expected_results.delete();
         error_count    = 0;
         leftovers_done = 1'b0;
      end else begin
         // Compare a result transfer against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("slot_index", 32'(want.slot_index),
                           32'(rsp_data.slot_index));
               check_field("out_key", 32'(want.out_key), 32'(rsp_data.out_key));
               check_field("out_payload", want.out_payload, rsp_data.out_payload);
            end
         end
         // Predict the result of a request transfer
         if (req_valid && !req_stall)
            expected_results.push_back(serve_request(req_data));
         // Track the slot count
         if (csr_valid && csr_ready)
            slot_count = csr_data;
         // Count expectations still open at the end of the run
         if (final_check && !leftovers_done) begin
            if (expected_results.size() != 0) begin
               $display("%0t: results missing, expected %0d more, actual 0", $time,
                        expected_results.size());
               error_count += expected_results.size();
            end
            leftovers_done = 1'b1;
         end
      end
      pending  <= expected_results.size();
      failures <= error_count;
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the tagged slot buffer testbench: clock, reset, request and slot-count
// stimulus, response stall pattern and verdict. Depends on tsb_pkg, tsb_checker
// and tagged_slot_buffer_core.
module testbench;
   import tsb_pkg::*;

   localparam int RANDOM_ITEMS = 1130;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 400;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data    = CNT_RESET;
   logic             final_check = 1'b0;
   int               pending;
   int               failures;
   int               cycle_count = 0;

   tagged_slot_buffer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   tsb_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .final_check (final_check),
      .pending     (pending),
      .failures    (failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // End the run on a hung handshake
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offer one request and hold it until the transfer
   task automatic offer_request(action_type act, logic [KEY_W-1:0] k,
                                logic [PAYLOAD_W-1:0] p);
      req_type r;
      r.action  = act;
      r.key     = k;
      r.payload = p;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every expected result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Write the slot count while the block is idle
   task automatic set_slot_count(logic [CNT_W-1:0] n);
      drain_results();
      csr_data  <= n;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Response side: stall in stretches of random density, with one long hold
   initial begin : rsp_sink
      int  taken;
      int  span;
      int  pct;
      bit  held;
      taken = 0;
      held  = 1'b0;
      forever begin
         span = $urandom_range(20, 120);
         case ($urandom_range(0, 4))
            0, 1:    pct = 0;
            2:       pct = 20;
            3:       pct = 50;
            default: pct = 85;
         endcase
         repeat (span) begin
            @(posedge clock);
            if (rsp_valid && !rsp_stall) taken++;
            if (!held && taken >= 300) begin
               held = 1'b1;
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD) @(posedge clock);
            end else begin
               rsp_stall <= ($urandom_range(0, 99) < pct);
            end
         end
      end
   end

   // Request side: directed cases, then random phases over many slot counts
   initial begin : stimulus
      logic [KEY_W-1:0] key_pool [8];
      logic [KEY_W-1:0] k;
      logic [CNT_W-1:0] n;
      action_type       act;
      int               sent;
      int               phase_len;
      int               done;
      int               burst;
      int               gap;
      int               write_pct;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty store, key and payload extremes, duplicate keys, slot reuse
      offer_request(ACT_READ, '0, '1);
      offer_request(ACT_WRITE, '0, '0);
      offer_request(ACT_WRITE, '1, '1);
      offer_request(ACT_WRITE, '0, 32'hA5A5_5A5A);
      offer_request(ACT_READ, '0, '0);
      offer_request(ACT_WRITE, 16'h1234, 32'hDEAD_BEEF);
      offer_request(ACT_READ, '0, '0);
      offer_request(ACT_READ, '1, '0);
      offer_request(ACT_READ, 16'h4321, '0);

      // Two slots: fill, overflow, then match the surviving entry
      set_slot_count(CNT_W'(2));
      offer_request(ACT_WRITE, 16'h00FF, 32'h0F0F_0F0F);
      offer_request(ACT_WRITE, 16'hFF00, 32'hF0F0_F0F0);
      offer_request(ACT_READ, 16'h1234, '0);

      // No slots searched: writes drop, reads miss
      set_slot_count('0);
      offer_request(ACT_WRITE, 16'h5555, 32'h5555_5555);
      offer_request(ACT_READ, 16'h00FF, '0);

      // Count beyond the slot array acts as the full array
      set_slot_count('1);
      offer_request(ACT_WRITE, 16'hAAAA, 32'hAAAA_AAAA);
      offer_request(ACT_READ, 16'h00FF, '0);

      // One slot, already occupied; entries above the count stay hidden
      set_slot_count(CNT_W'(1));
      offer_request(ACT_WRITE, 16'h7777, 32'h7777_7777);
      offer_request(ACT_READ, 16'hAAAA, '0);
      offer_request(ACT_READ, 16'hAAAA, '0);
      offer_request(ACT_WRITE, 16'h8000, 32'h8000_0000);

      for (int i = 0; i < 8; i++) key_pool[i] = KEY_W'($urandom);

      // Random phases, each after a drain and a new slot count
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       n = '0;
            1:       n = CNT_W'(1);
            2:       n = CNT_W'(2);
            3:       n = CNT_W'(SLOTS);
            4:       n = CNT_W'($urandom_range(SLOTS + 1, 31));
            default: n = CNT_W'($urandom_range(3, SLOTS));
         endcase
         set_slot_count(n);
         phase_len = $urandom_range(40, 140);
         if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
         write_pct = $urandom_range(30, 75);
         key_pool[$urandom_range(0, 7)] = KEY_W'($urandom);
         key_pool[$urandom_range(0, 7)] = KEY_W'($urandom);
         done = 0;
         while (done < phase_len) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && done < phase_len; b++) begin
               act = ($urandom_range(0, 99) < write_pct) ? ACT_WRITE : ACT_READ;
               k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                               : key_pool[$urandom_range(0, 7)];
               offer_request(act, k, PAYLOAD_W'($urandom));
               done++;
            end
            // Idle between bursts, sometimes not at all
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         sent += done;
      end

      // Let the last results drain, then close out the checker
      drain_results();
      repeat (10) @(posedge clock);
      final_check <= 1'b1;
      @(posedge clock);
      @(posedge clock);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
src/tsb_pkg.sv
src/tsb_ram.sv
src/tsb_slot_tags.sv
src/tagged_slot_buffer_core.sv
tb/tsb_checker.sv
tb/testbench.sv
